### hdl/cfdil_pkg.sv
// Shared constants, types and helpers for the clipped-flag 3x3 dilation block.
// No dependencies; imported by the top level and the output queue.
package cfdil_pkg;

  // Default geometry limits, handed to the top-level parameters.
  localparam int DEF_MAX_WIDTH  = 2048;
  localparam int DEF_MAX_HEIGHT = 4096;

  // Register reset values before saturation to the parameter limits.
  localparam int RESET_WIDTH  = 2048;
  localparam int RESET_HEIGHT = 4096;

  // Bit position of the clipped flag within each channel flag byte.
  localparam int          CLIP_BIT  = 0;
  localparam logic [7:0]  CLIP_MASK = 8'(1 << CLIP_BIT);

  // Configuration port.
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 13;
  localparam int WIDTH_REG_W  = 12;
  localparam int HEIGHT_REG_W = 13;
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

  // Input item kinds (tuser).
  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_FLUSH = 1'b1;

  // Line memory word: {upper clip bits [26:24], centre row flags [23:0]}.
  localparam int FLAGS_W = 24;
  localparam int MEM_W   = FLAGS_W + 3;
  // Window column: {below clips [29:27], above clips [26:24], flags [23:0]}.
  localparam int COL_W   = FLAGS_W + 6;

  // Output queue.
  localparam int OUTQ_DEPTH = 4;
  localparam int OUTQ_PTR_W = $clog2(OUTQ_DEPTH);
  localparam int OUTQ_CNT_W = $clog2(OUTQ_DEPTH + 1);

  typedef struct packed {
    logic       last;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } result_t;

  // Clipped bits of the r, g, b bytes packed as {b, g, r}.
  function automatic logic [2:0] clip3(input logic [FLAGS_W-1:0] f);
    clip3 = {f[16 + CLIP_BIT], f[8 + CLIP_BIT], f[CLIP_BIT]};
  endfunction

  // Clipped bits of the rows above and below a window column.
  function automatic logic [2:0] vclips(input logic [COL_W-1:0] col);
    vclips = col[26:24] | col[29:27];
  endfunction

endpackage

### hdl/cfdil_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module cfdil_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### hdl/cfdil_out_queue.sv
// Small result queue between the dilation datapath and the output stream.
// Depends on cfdil_pkg (result_t, queue depth constants).
module cfdil_out_queue import cfdil_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  result_t               push_data,
  input  logic                  pop_ready,
  output logic                  out_valid,
  output result_t               out_data,
  output logic [OUTQ_CNT_W-1:0] count
);

  result_t                 entries [OUTQ_DEPTH];
  logic [OUTQ_PTR_W-1:0]   head;
  logic [OUTQ_PTR_W-1:0]   tail;
  logic                    pop;

  function automatic logic [OUTQ_PTR_W-1:0] ptr_inc(input logic [OUTQ_PTR_W-1:0] p);
    ptr_inc = (p == OUTQ_PTR_W'(OUTQ_DEPTH - 1)) ? '0 : p + OUTQ_PTR_W'(1);
  endfunction

  assign out_valid = (count != '0);
  assign out_data  = entries[head];
  assign pop       = out_valid & pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[tail] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        tail <= ptr_inc(tail);
      end
      if (pop) begin
        head <= ptr_inc(head);
      end
      unique case ({push, pop})
        2'b10:   count <= count + OUTQ_CNT_W'(1);
        2'b01:   count <= count - OUTQ_CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

### hdl/clipped_flag_dilation_3x3.sv
// Top level of the clipped-flag 3x3 dilation block.
// Depends on cfdil_pkg, cfdil_ram (line memory) and cfdil_out_queue.
//
// Streams raster-order pixels carrying red, green and blue flag bytes and
// ORs each channel's clipped bit over the 3x3 neighborhood (neighbors outside
// the image are left out); all other flag bits of the center pixel pass as
// they are. The block takes one transfer per clock while the output queue has
// room: the only per-item loop is a read-modify-write of one line-memory word
// per pixel, and the registered read data is covered by forwarding when the
// same column is read and written back in adjacent cycles (image width of one,
// or the first pixel after an image end). A pixel's result leaves one row plus
// one pixel of input transfers after the pixel; it passes the stage 1 registers
// and the output queue before it can be taken on the output. After the image's
// last pixel, send image_width + 1 flush items (tuser = 1) to drain; a pixel
// item sent while draining counts as a flush, and a flush sent before the
// image end is dropped with no result. The result of the final pixel carries
// m_tlast, and the next transfer starts a new image. Writing either register
// restarts the image; write only while the block is idle. Register values of
// zero count as one and values above the limits saturate. The line memory
// holds MAX_WIDTH words of 27 bits and needs no clearing after reset.
module clipped_flag_dilation_3x3 import cfdil_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                   clk,
  input  logic                   rst,
  // configuration write port
  input  logic                   cfg_wr_en,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  // input stream
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [23:0]            s_tdata,   // red_flags_in, green_flags_in, blue_flags_in
  input  logic                   s_tuser,   // kind
  // output stream
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [31:0]            m_tdata,   // red, green, blue, pixel flags out
  output logic                   m_tlast    // last_pixel
);

  localparam int CW = $clog2(MAX_WIDTH);        // column index
  localparam int WW = $clog2(MAX_WIDTH + 1);    // width register
  localparam int HW = $clog2(MAX_HEIGHT + 1);   // height register
  localparam int RW = $clog2(MAX_HEIGHT + 2);   // row count, incl. drain row
  localparam int WIDTH_INIT  = (RESET_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RESET_WIDTH;
  localparam int HEIGHT_INIT = (RESET_HEIGHT > MAX_HEIGHT) ? MAX_HEIGHT : RESET_HEIGHT;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [WW-1:0]           image_width;
  logic [HW-1:0]           image_height;
  logic [WW-1:0]           width_sat;
  logic [HW-1:0]           height_sat;
  logic [WIDTH_REG_W-1:0]  cfg_w;
  logic [HEIGHT_REG_W-1:0] cfg_h;
  logic                    restart;

  assign cfg_w   = cfg_data[WIDTH_REG_W-1:0];
  assign cfg_h   = cfg_data[HEIGHT_REG_W-1:0];
  assign restart = cfg_wr_en;

  always_comb begin
    if (cfg_w == '0) begin
      width_sat = WW'(1);
    end else if (32'(cfg_w) > 32'(MAX_WIDTH)) begin
      width_sat = WW'(MAX_WIDTH);
    end else begin
      width_sat = WW'(cfg_w);
    end
    if (cfg_h == '0) begin
      height_sat = HW'(1);
    end else if (32'(cfg_h) > 32'(MAX_HEIGHT)) begin
      height_sat = HW'(MAX_HEIGHT);
    end else begin
      height_sat = HW'(cfg_h);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WW'(WIDTH_INIT);
      image_height <= HW'(HEIGHT_INIT);
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:  image_width  <= width_sat;
        REG_IMAGE_HEIGHT: image_height <= height_sat;
        default:          ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 0: accept, position tracking, line memory read
  // ---------------------------------------------------------------------------
  logic [CW-1:0]   column_count;
  logic [RW-1:0]   row_count;
  logic            accept;
  logic            draining;
  logic            ignore_item;
  logic            take;
  logic            at_last;
  logic            col_wrap;
  logic [FLAGS_W-1:0] fresh;

  logic                  st1_valid;
  logic [CW-1:0]         st1_col;
  logic                  st1_c0;
  logic                  st1_c_ge2;
  logic                  st1_r_ge1;
  logic                  st1_r_ge2;
  logic                  st1_last;
  logic [FLAGS_W-1:0]    st1_fresh;

  logic [OUTQ_CNT_W-1:0] q_count;

  // Room for the result of the item in stage 1 and of the one taken now.
  assign s_tready = ((OUTQ_CNT_W + 1)'(q_count) + (OUTQ_CNT_W + 1)'(st1_valid))
                    <= (OUTQ_CNT_W + 1)'(OUTQ_DEPTH - 1);

  assign accept      = s_tvalid & s_tready;
  assign draining    = (row_count >= RW'(image_height));
  assign ignore_item = !draining && (s_tuser == KIND_FLUSH);
  assign take        = accept && !ignore_item;
  assign at_last     = (column_count == '0) && (row_count == RW'(image_height) + RW'(1));
  assign col_wrap    = ((WW'(column_count) + WW'(1)) == image_width);
  assign fresh       = draining ? '0 : s_tdata[FLAGS_W-1:0];

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (take) begin
      if (at_last) begin
        column_count <= '0;
        row_count    <= '0;
      end else if (col_wrap) begin
        column_count <= '0;
        row_count    <= row_count + RW'(1);
      end else begin
        column_count <= column_count + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st1_valid <= 1'b0;
    end else begin
      st1_valid <= take;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      st1_col   <= column_count;
      st1_c0    <= (column_count == '0);
      st1_c_ge2 <= (column_count >= CW'(2));
      st1_r_ge1 <= (row_count >= RW'(1));
      st1_r_ge2 <= (row_count >= RW'(2));
      st1_last  <= at_last;
      st1_fresh <= fresh;
    end
  end

  // ---------------------------------------------------------------------------
  // Line memory: per column {clip bits of the row above, flags of last row}
  // ---------------------------------------------------------------------------
  logic [MEM_W-1:0] mem_rd_data;
  logic [MEM_W-1:0] mem_wr_data;
  logic [MEM_W-1:0] mem_q;
  logic [MEM_W-1:0] fwd_data;
  logic             fwd_valid;

  cfdil_ram #(
    .WIDTH (MEM_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk     (clk),
    .wr_en   (st1_valid),
    .wr_addr (st1_col),
    .wr_data (mem_wr_data),
    .rd_en   (take),
    .rd_addr (column_count),
    .rd_data (mem_rd_data)
  );

  // Same column read while stage 1 writes it back: forward the new word.
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid <= 1'b0;
    end else begin
      fwd_valid <= take && st1_valid && (column_count == st1_col);
    end
  end

  always_ff @(posedge clk) begin
    fwd_data <= mem_wr_data;
  end

  assign mem_q = fwd_valid ? fwd_data : mem_rd_data;

  // ---------------------------------------------------------------------------
  // Stage 1: build window column, write back, shift window, form result
  // ---------------------------------------------------------------------------
  logic [FLAGS_W-1:0] old_flags;
  logic [2:0]         top_clips;
  logic [COL_W-1:0]   col;
  logic [COL_W-1:0]   win1, win2;
  logic [COL_W-1:0]   right_col;
  logic               has_left;
  logic               has_right;
  logic [2:0]         spread;
  logic               res_push;
  result_t            res;

  assign old_flags   = mem_q[FLAGS_W-1:0];
  assign top_clips   = st1_r_ge2 ? mem_q[MEM_W-1:FLAGS_W] : 3'b000;
  assign col         = {clip3(st1_fresh), top_clips, old_flags};
  assign mem_wr_data = {clip3(old_flags), st1_fresh};

  // Center is always the previous newest column; at row start the right
  // neighbor is outside the image.
  always_comb begin
    if (st1_c0) begin
      right_col = '0;
      has_left  = (image_width > WW'(1));
      has_right = 1'b0;
      res_push  = st1_valid && st1_r_ge2;
    end else begin
      right_col = col;
      has_left  = st1_c_ge2;
      has_right = 1'b1;
      res_push  = st1_valid && st1_r_ge1;
    end
    spread = vclips(win2);
    if (has_left) begin
      spread = spread | vclips(win1) | clip3(win1[FLAGS_W-1:0]);
    end
    if (has_right) begin
      spread = spread | vclips(right_col) | clip3(right_col[FLAGS_W-1:0]);
    end
    res.red   = win2[7:0]   | (spread[0] ? CLIP_MASK : 8'h00);
    res.green = win2[15:8]  | (spread[1] ? CLIP_MASK : 8'h00);
    res.blue  = win2[23:16] | (spread[2] ? CLIP_MASK : 8'h00);
    res.last  = st1_c0 && st1_last;
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      win1 <= '0;
      win2 <= '0;
    end else if (st1_valid) begin
      if (st1_c0) begin
        win1 <= '0;
        win2 <= st1_last ? '0 : col;
      end else begin
        win1 <= win2;
        win2 <= col;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output queue and stream packing
  // ---------------------------------------------------------------------------
  result_t q_data;

  cfdil_out_queue u_out_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (res_push),
    .push_data (res),
    .pop_ready (m_tready),
    .out_valid (m_tvalid),
    .out_data  (q_data),
    .count     (q_count)
  );

  assign m_tdata = {q_data.red | q_data.green | q_data.blue,
                    q_data.blue, q_data.green, q_data.red};
  assign m_tlast = q_data.last;

endmodule
